// ===== rtl/core/bbc_pkg.sv =====
// Package for the clipped 3x3 box blur: payload types, register indexes,
// controller/datapath command and status structs, divide-by-count helpers.
// No dependencies.
`default_nettype none
package bbc_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned RECIP_SH   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [1:0] SLOT_UP_LEFT  = 2'd0;
  localparam logic [1:0] SLOT_UP_HERE  = 2'd1;
  localparam logic [1:0] SLOT_CUR_LEFT = 2'd2;
  localparam logic [1:0] SLOT_CUR_HERE = 2'd3;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       run_last;
    logic       frame_done;
  } res_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } px_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       sum;
    logic       div;
    logic       advance;
    logic [1:0] slot;
    logic       run_last;
    logic       frame_done;
  } cmd_t;

  typedef struct packed {
    logic [3:0] emit;
    logic       out_busy;
  } stat_t;

  function automatic logic [3:0] cell_count(input logic [1:0] r0, input logic [1:0] c0);
    logic [1:0] nr;
    logic [1:0] nc;
    nr = 2'd3 - r0;
    nc = 2'd3 - c0;
    return 4'(nr) * 4'(nc);
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
    logic [RECIP_W-1:0] v;
    unique case (cnt)
      4'd1:    v = 17'd65536;
      4'd2:    v = 17'd32768;
      4'd3:    v = 17'd21846;
      4'd4:    v = 17'd16384;
      4'd6:    v = 17'd10923;
      4'd9:    v = 17'd7282;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bbc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bbc_ctrl.sv =====
// Controller for the box blur: sequences line read, window shift and up to
// four results per pixel. Depends on bbc_pkg.
`default_nettype none
module bbc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bbc_pkg::stat_t stat,
  output bbc_pkg::cmd_t       cmd
);
  import bbc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_NEXT, S_DIV} state_t;

  state_t     state;
  logic [3:0] pend;
  logic [1:0] slot;
  logic [1:0] first;

  always_comb begin
    priority if (pend[0]) first = SLOT_UP_LEFT;
    else if (pend[1]) first = SLOT_UP_HERE;
    else if (pend[2]) first = SLOT_CUR_LEFT;
    else first = SLOT_CUR_HERE;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.slot = slot;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_READ: cmd.shift = 1'b1;
      S_NEXT: begin
        cmd.sum     = (pend != 4'd0);
        cmd.advance = (pend == 4'd0);
        cmd.slot    = first;
      end
      S_DIV: begin
        cmd.div        = !stat.out_busy;
        cmd.run_last   = (pend == 4'd0);
        cmd.frame_done = (slot == SLOT_CUR_HERE);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= '0;
      slot  <= SLOT_UP_LEFT;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_READ;
        end
        S_READ: begin
          pend  <= stat.emit;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (pend == 4'd0) begin
            state <= S_IDLE;
          end else begin
            slot        <= first;
            pend[first] <= 1'b0;
            state       <= S_DIV;
          end
        end
        S_DIV: if (!stat.out_busy) begin
          state <= S_NEXT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bbc_dp.sv =====
// Datapath for the box blur: config registers, positions, line stores,
// 3x3 window, clipped sums, divide by count and the output register.
// Depends on bbc_pkg and bbc_ram.
`default_nettype none
module bbc_dp #(
  parameter int unsigned MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bbc_pkg::pix_in_t                    in_data,
  input  wire logic                                cfg_we,
  input  wire logic [bbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bbc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output bbc_pkg::res_t                            out_data,
  input  wire bbc_pkg::cmd_t                       cmd,
  output bbc_pkg::stat_t                           stat
);
  import bbc_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [31:0]           w_eff;
  logic [31:0]           h_eff;
  logic [CW-1:0]         col;
  logic [RW-1:0]         row;
  logic                  lastcol;
  logic                  lastrow;
  logic                  r_ge1;
  logic                  r_ge2;
  logic                  c_ge1;
  logic                  c_ge2;
  px_t                   pix;
  px_t                   win [3][3];
  logic [23:0]           older_rd;
  logic [23:0]           newer_rd;
  logic [1:0]            r0;
  logic [1:0]            c0;
  logic [SUM_W-1:0]      sr;
  logic [SUM_W-1:0]      sg;
  logic [SUM_W-1:0]      sb;
  logic [SUM_W-1:0]      hr;
  logic [SUM_W-1:0]      hg;
  logic [SUM_W-1:0]      hb;
  logic [3:0]            cnt;
  logic [3:0]            cnt_q;
  logic [SUM_W+RECIP_W-1:0] pr;
  logic [SUM_W+RECIP_W-1:0] pg;
  logic [SUM_W+RECIP_W-1:0] pb;
  logic [RW-1:0]         o_row;
  logic [CW-1:0]         o_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 11'd480;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  always_comb begin
    if (image_width == '0) w_eff = 32'd1;
    else if (32'(image_width) > MAX_WIDTH) w_eff = 32'(MAX_WIDTH);
    else w_eff = 32'(image_width);
    if (image_height == '0) h_eff = 32'd1;
    else if (32'(image_height) > MAX_HEIGHT) h_eff = 32'(MAX_HEIGHT);
    else h_eff = 32'(image_height);
  end

  assign lastcol = 32'(col) >= (w_eff - 32'd1);
  assign lastrow = 32'(row) >= (h_eff - 32'd1);
  assign r_ge1   = (32'(row) >= 32'd1);
  assign r_ge2   = (32'(row) >= 32'd2);
  assign c_ge1   = (32'(col) >= 32'd1);
  assign c_ge2   = (32'(col) >= 32'd2);

  always_comb begin
    stat.emit[SLOT_UP_LEFT]  = r_ge1 && c_ge1;
    stat.emit[SLOT_UP_HERE]  = r_ge1 && lastcol;
    stat.emit[SLOT_CUR_LEFT] = lastrow && c_ge1;
    stat.emit[SLOT_CUR_HERE] = lastrow && lastcol;
    stat.out_busy            = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (cmd.advance) begin
      if (lastcol) begin
        col <= '0;
        row <= lastrow ? '0 : RW'(32'(row) + 32'd1);
      end else begin
        col <= CW'(32'(col) + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix <= px_t'(in_data);
    end
  end

  bbc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (col),
    .wdata (newer_rd),
    .re    (cmd.load),
    .raddr (col),
    .rdata (older_rd)
  );

  bbc_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (col),
    .wdata (pix),
    .re    (cmd.load),
    .raddr (col),
    .rdata (newer_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= px_t'(older_rd);
      win[1][2] <= px_t'(newer_rd);
      win[2][2] <= pix;
    end
  end

  always_comb begin
    if (cmd.slot == SLOT_UP_LEFT || cmd.slot == SLOT_UP_HERE) begin
      r0 = r_ge2 ? 2'd0 : 2'd1;
    end else begin
      r0 = r_ge1 ? 2'd1 : 2'd2;
    end
    if (cmd.slot == SLOT_UP_LEFT || cmd.slot == SLOT_CUR_LEFT) begin
      c0 = c_ge2 ? 2'd0 : 2'd1;
    end else begin
      c0 = c_ge1 ? 2'd1 : 2'd2;
    end
    cnt = cell_count(r0, c0);
    sr = '0;
    sg = '0;
    sb = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (2'(i) >= r0 && 2'(j) >= c0) begin
          sr = sr + SUM_W'(win[i][j].r);
          sg = sg + SUM_W'(win[i][j].g);
          sb = sb + SUM_W'(win[i][j].b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      hr    <= sr + SUM_W'(cnt >> 1);
      hg    <= sg + SUM_W'(cnt >> 1);
      hb    <= sb + SUM_W'(cnt >> 1);
      cnt_q <= cnt;
      o_row <= (cmd.slot == SLOT_UP_LEFT || cmd.slot == SLOT_UP_HERE) ?
               RW'(32'(row) - 32'd1) : row;
      o_col <= (cmd.slot == SLOT_UP_LEFT || cmd.slot == SLOT_CUR_LEFT) ?
               CW'(32'(col) - 32'd1) : col;
    end
  end

  assign pr = (SUM_W+RECIP_W)'(hr) * (SUM_W+RECIP_W)'(recip(cnt_q));
  assign pg = (SUM_W+RECIP_W)'(hg) * (SUM_W+RECIP_W)'(recip(cnt_q));
  assign pb = (SUM_W+RECIP_W)'(hb) * (SUM_W+RECIP_W)'(recip(cnt_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.div) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      out_data.out_row    <= 10'(o_row);
      out_data.out_col    <= 10'(o_col);
      out_data.out_red    <= 8'(pr >> RECIP_SH);
      out_data.out_green  <= 8'(pg >> RECIP_SH);
      out_data.out_blue   <= 8'(pb >> RECIP_SH);
      out_data.run_last   <= cmd.run_last;
      out_data.frame_done <= cmd.frame_done;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/box_blur_3x3_clipped.sv =====
// Top level of the clipped 3x3 box blur: controller plus datapath.
// Depends on bbc_pkg, bbc_ctrl, bbc_dp (and bbc_ram below it).
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_data  (pix_in_t)
//   out      out_valid / out_ready  out_data (res_t)
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Per pixel it makes a line store read, a window shift, then a sum and a
// divide step for each of the n = 0..4 results it releases, and last a
// position advance; a divide waits while out_ready has not taken the last result.
// The next pixel is taken while the last result still waits to be taken.
// Reset is synchronous; line stores need no clearing, cfg writes always taken.
`default_nettype none
module box_blur_3x3_clipped #(
  parameter int unsigned MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire bbc_pkg::pix_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bbc_pkg::res_t                       out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbc_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
